/* sv/lsau_pkg.sv */
// Package for the load/store address unit: access kind codes, register
// indexes, reset values, instruction field positions and the offset shifter.
// No dependencies.
package lsau_pkg;

   typedef logic [2:0] kind_type;
   typedef logic [2:0] reg_index_type;

   localparam kind_type KIND_LOAD       = 3'd0;
   localparam kind_type KIND_STORE      = 3'd1;
   localparam kind_type KIND_GPIO_LOAD  = 3'd2;
   localparam kind_type KIND_GPIO_STORE = 3'd3;
   localparam kind_type KIND_GPIO_CLEAR = 3'd4;
   localparam kind_type KIND_GPIO_SET   = 3'd5;
   localparam kind_type KIND_OOB        = 3'd6;

   localparam reg_index_type REG_GPIO_BASE  = 3'd0;
   localparam reg_index_type REG_GPIO_SPAN  = 3'd1;
   localparam reg_index_type REG_GPIO_CLEAR = 3'd2;
   localparam reg_index_type REG_GPIO_SET   = 3'd3;
   localparam reg_index_type REG_MEM_LIMIT  = 3'd4;

   localparam int CSR_ADDR_WIDTH = 5;

   localparam logic [31:0] RESET_GPIO_BASE  = 32'h2020_0000;
   localparam logic [7:0]  RESET_GPIO_SPAN  = 8'd8;
   localparam logic [31:0] RESET_GPIO_CLEAR = 32'h2020_0028;
   localparam logic [31:0] RESET_GPIO_SET   = 32'h2020_001C;
   localparam logic [30:0] RESET_MEM_LIMIT  = 31'h0001_0000;

   localparam int BIT_REG_OFFSET = 25;
   localparam int BIT_PRE_INDEX  = 24;
   localparam int BIT_UP         = 23;
   localparam int BIT_LOAD       = 20;

   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;
   localparam logic [1:0] SHIFT_ROR = 2'd3;

   // A shift amount of zero passes the value through for every shift type.
   function automatic logic [31:0] shift_offset(input logic [31:0] value,
                                                input logic [4:0]  amount,
                                                input logic [1:0]  kind);
      logic [63:0] rotated;
      logic [31:0] result;
      rotated = {value, value} >> amount;
      result  = value;
      if (amount != 5'd0) begin
         case (kind)
            SHIFT_LSL: result = value << amount;
            SHIFT_LSR: result = value >> amount;
            SHIFT_ASR: result = 32'($signed(value) >>> amount);
            SHIFT_ROR: result = rotated[31:0];
            default:   result = value;
         endcase
      end
      return result;
   endfunction

endpackage

/* sv/load_store_address_unit_core.sv */
// Load/store address unit core: offset forming, indexing and access classification.
// Depends on lsau_pkg.
//
// The unit takes one request in every clock cycle and never raises busy.
// Each request gives exactly one result, marked by rsp_strobe, after passing
// through the registered stages in order: the first stage forms the shifted
// or immediate offset, the second adds or subtracts it from the base and picks
// the access address, the third compares that address against the GPIO region,
// the GPIO clear and set addresses and the memory limit. The receiver cannot
// stall the unit, so results leave in request order at the request rate.
// The user must write configuration registers through the APB port only while
// no request is in flight; the unit itself does not enforce it.
module load_store_address_unit_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [31:0]                          req_instr_word,
   input  logic [31:0]                          req_base_value,
   input  logic [31:0]                          req_offset_reg_value,
   output logic                                 rsp_strobe,
   output logic [31:0]                          rsp_access_addr,
   output lsau_pkg::kind_type                   rsp_access_kind,
   output logic [3:0]                           rsp_data_reg,
   output logic [3:0]                           rsp_base_reg,
   output logic                                 rsp_base_write_en,
   output logic [31:0]                          rsp_base_write_value,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lsau_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import lsau_pkg::*;

   logic [31:0] gpio_base_ff;
   logic [7:0]  gpio_span_ff;
   logic [31:0] gpio_clear_ff;
   logic [31:0] gpio_set_ff;
   logic [30:0] mem_limit_ff;

   reg_index_type csr_index;
   logic          csr_write;

   logic        v1_ff, v2_ff, v3_ff;
   logic [31:0] off1_ff, off1_in;
   logic [31:0] base1_ff;
   logic        up1_ff, pre1_ff, load1_ff;
   logic [3:0]  rd1_ff, rn1_ff;

   logic [31:0] wb2_ff, wb2_in;
   logic [31:0] addr2_ff;
   logic        pre2_ff, load2_ff;
   logic [3:0]  rd2_ff, rn2_ff;

   logic [31:0] addr3_ff;
   kind_type    kind3_ff, kind3_in;
   logic [31:0] wb3_ff;
   logic        wbe3_ff;
   logic [3:0]  rd3_ff, rn3_ff;

   logic [32:0] region_end;
   logic        in_region;
   logic        out_of_bounds;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign csr_index = paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gpio_base_ff  <= RESET_GPIO_BASE;
         gpio_span_ff  <= RESET_GPIO_SPAN;
         gpio_clear_ff <= RESET_GPIO_CLEAR;
         gpio_set_ff   <= RESET_GPIO_SET;
         mem_limit_ff  <= RESET_MEM_LIMIT;
      end else if (csr_write) begin
         case (csr_index)
            REG_GPIO_BASE:  gpio_base_ff  <= pwdata;
            REG_GPIO_SPAN:  gpio_span_ff  <= pwdata[7:0];
            REG_GPIO_CLEAR: gpio_clear_ff <= pwdata;
            REG_GPIO_SET:   gpio_set_ff   <= pwdata;
            REG_MEM_LIMIT:  mem_limit_ff  <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GPIO_BASE:  prdata = gpio_base_ff;
         REG_GPIO_SPAN:  prdata = {24'd0, gpio_span_ff};
         REG_GPIO_CLEAR: prdata = gpio_clear_ff;
         REG_GPIO_SET:   prdata = gpio_set_ff;
         REG_MEM_LIMIT:  prdata = {1'b0, mem_limit_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // Stage 1: offset.
   always_comb begin
      if (req_instr_word[BIT_REG_OFFSET]) begin
         off1_in = shift_offset(req_offset_reg_value, req_instr_word[11:7],
                                req_instr_word[6:5]);
      end else begin
         off1_in = {20'd0, req_instr_word[11:0]};
      end
   end

   // Stage 2: indexing.
   always_comb begin
      if (up1_ff) begin
         wb2_in = base1_ff + off1_ff;
      end else begin
         wb2_in = base1_ff - off1_ff;
      end
   end

   // Stage 3: classification, checked in priority order.
   assign region_end    = {1'b0, gpio_base_ff} + {25'd0, gpio_span_ff};
   assign in_region     = (addr2_ff >= gpio_base_ff) && ({1'b0, addr2_ff} <= region_end);
   assign out_of_bounds = addr2_ff[31] || (addr2_ff[30:0] > mem_limit_ff);

   always_comb begin
      if (in_region) begin
         kind3_in = load2_ff ? KIND_GPIO_LOAD : KIND_GPIO_STORE;
      end else if (addr2_ff == gpio_clear_ff) begin
         kind3_in = KIND_GPIO_CLEAR;
      end else if (addr2_ff == gpio_set_ff) begin
         kind3_in = KIND_GPIO_SET;
      end else if (out_of_bounds) begin
         kind3_in = KIND_OOB;
      end else begin
         kind3_in = load2_ff ? KIND_LOAD : KIND_STORE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      off1_ff  <= off1_in;
      base1_ff <= req_base_value;
      up1_ff   <= req_instr_word[BIT_UP];
      pre1_ff  <= req_instr_word[BIT_PRE_INDEX];
      load1_ff <= req_instr_word[BIT_LOAD];
      rd1_ff   <= req_instr_word[15:12];
      rn1_ff   <= req_instr_word[19:16];

      wb2_ff   <= wb2_in;
      addr2_ff <= pre1_ff ? wb2_in : base1_ff;
      pre2_ff  <= pre1_ff;
      load2_ff <= load1_ff;
      rd2_ff   <= rd1_ff;
      rn2_ff   <= rn1_ff;

      addr3_ff <= addr2_ff;
      kind3_ff <= kind3_in;
      wb3_ff   <= wb2_ff;
      wbe3_ff  <= !pre2_ff;
      rd3_ff   <= rd2_ff;
      rn3_ff   <= rn2_ff;
   end

   assign rsp_strobe           = v3_ff;
   assign rsp_access_addr      = addr3_ff;
   assign rsp_access_kind      = kind3_ff;
   assign rsp_data_reg         = rd3_ff;
   assign rsp_base_reg         = rn3_ff;
   assign rsp_base_write_en    = wbe3_ff;
   assign rsp_base_write_value = wb3_ff;

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_strobe)
      else $error("Accepted request produced no result after three cycles.");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 3))
      else $error("Result strobe without a matching request.");

   a_pre_index_address: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_base_write_en |-> rsp_access_addr == rsp_base_write_value)
      else $error("Pre-indexed address differs from the indexed base.");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_access_kind <= KIND_OOB)
      else $error("Access kind out of range.");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for load_store_address_unit_core: directed and random requests
// checked against a table or a behavioral model of offsets, indexing and classification.
// Depends on lsau_pkg and load_store_address_unit_core.
module testbench;
   import lsau_pkg::*;

   typedef struct packed {
      logic [31:0] addr;
      kind_type    kind;
      logic [3:0]  data_reg;
      logic [3:0]  base_reg;
      logic        wb_en;
      logic [31:0] wb_value;
   } transfer_type;

   typedef struct packed {
      logic [31:0] gpio_base;
      logic [7:0]  gpio_span;
      logic [31:0] clear_addr;
      logic [31:0] set_addr;
      logic [30:0] mem_limit;
   } address_map_type;

   typedef struct packed {
      logic [31:0]  instr;
      logic [31:0]  base;
      logic [31:0]  rm;
      logic         typed;
      transfer_type want;
   } directed_row_type;

   localparam int N_DIRECTED      = 27;
   localparam int N_PHASES        = 8;
   localparam int ITEMS_PER_PHASE = 90;

   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{32'hE5912010, 32'h0000_1000, 32'h0, 1'b1,
        '{32'h0000_1010, KIND_LOAD, 4'd2, 4'd1, 1'b0, 32'h0000_1010}},
      '{32'hE40FFFFF, 32'h0000_2000, 32'h0, 1'b1,
        '{32'h0000_2000, KIND_STORE, 4'd15, 4'd15, 1'b1, 32'h0000_1001}},
      '{32'hE5800000, 32'h0, 32'hFFFF_FFFF, 1'b1,
        '{32'h0, KIND_STORE, 4'd0, 4'd0, 1'b0, 32'h0}},
      '{32'hE4912004, 32'h0000_3000, 32'h0, 1'b1,
        '{32'h0000_3000, KIND_LOAD, 4'd2, 4'd1, 1'b1, 32'h0000_3004}},
      '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{32'hFFFF_FFFF, KIND_OOB, 4'd0, 4'd0, 1'b1, 32'hFFFF_FFFF}},
      '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'hE7912203, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7912223, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7912243, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7912263, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7912F83, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7912FA3, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7912FC3, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7912003, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7912023, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7912043, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7112243, 32'h0, 32'h8000_0011, 1'b0, '0},
      '{32'hE7912063, 32'h0000_1000, 32'h0000_0040, 1'b1,
        '{32'h0000_1040, KIND_LOAD, 4'd2, 4'd1, 1'b0, 32'h0000_1040}},
      '{32'hE5912000, 32'h2020_0000, 32'h0, 1'b1,
        '{32'h2020_0000, KIND_GPIO_LOAD, 4'd2, 4'd1, 1'b0, 32'h2020_0000}},
      '{32'hE5812008, 32'h2020_0000, 32'h0, 1'b1,
        '{32'h2020_0008, KIND_GPIO_STORE, 4'd2, 4'd1, 1'b0, 32'h2020_0008}},
      '{32'hE5812009, 32'h2020_0000, 32'h0, 1'b1,
        '{32'h2020_0009, KIND_OOB, 4'd2, 4'd1, 1'b0, 32'h2020_0009}},
      '{32'hE5012001, 32'h2020_0000, 32'h0, 1'b1,
        '{32'h201F_FFFF, KIND_OOB, 4'd2, 4'd1, 1'b0, 32'h201F_FFFF}},
      '{32'hE5912000, 32'h2020_0028, 32'h0, 1'b1,
        '{32'h2020_0028, KIND_GPIO_CLEAR, 4'd2, 4'd1, 1'b0, 32'h2020_0028}},
      '{32'hE5812000, 32'h2020_001C, 32'h0, 1'b1,
        '{32'h2020_001C, KIND_GPIO_SET, 4'd2, 4'd1, 1'b0, 32'h2020_001C}},
      '{32'hE5912000, 32'h0001_0000, 32'h0, 1'b1,
        '{32'h0001_0000, KIND_LOAD, 4'd2, 4'd1, 1'b0, 32'h0001_0000}},
      '{32'hE5912000, 32'h0001_0001, 32'h0, 1'b1,
        '{32'h0001_0001, KIND_OOB, 4'd2, 4'd1, 1'b0, 32'h0001_0001}},
      '{32'hE5912000, 32'h8000_0000, 32'h0, 1'b1,
        '{32'h8000_0000, KIND_OOB, 4'd2, 4'd1, 1'b0, 32'h8000_0000}}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_instr_word = '0;
   logic [31:0] req_base_value = '0;
   logic [31:0] req_offset_reg_value = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_access_addr;
   kind_type    rsp_access_kind;
   logic [3:0]  rsp_data_reg;
   logic [3:0]  rsp_base_reg;
   logic        rsp_base_write_en;
   logic [31:0] rsp_base_write_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic         req_typed = 1'b0;
   transfer_type req_typed_value = '0;

   address_map_type map_cfg = '{RESET_GPIO_BASE, RESET_GPIO_SPAN, RESET_GPIO_CLEAR,
                                RESET_GPIO_SET, RESET_MEM_LIMIT};
   transfer_type    pending_transfers [$];
   transfer_type    oldest;
   int              fail_count = 0;
   int              requests_sent = 0;
   int              kind_seen [8] = '{default: 0};

   load_store_address_unit_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("[load_store_address_unit_core] ERROR");
      $finish;
   end

   function automatic logic [31:0] transfer_offset(logic [31:0] instr, logic [31:0] rm);
      logic [4:0]  amount;
      logic [31:0] off;
      logic [63:0] wide;
      amount = instr[11:7];
      wide   = {{32{rm[31]}}, rm} >> amount;
      if (!instr[BIT_REG_OFFSET]) begin
         off = {20'h0, instr[11:0]};
      end else if (amount == 5'd0) begin
         off = rm;
      end else begin
         case (instr[6:5])
            SHIFT_LSL: off = rm << amount;
            SHIFT_LSR: off = rm >> amount;
            SHIFT_ASR: off = wide[31:0];
            SHIFT_ROR: off = (rm >> amount) | (rm << (32 - amount));
            default:   off = rm;
         endcase
      end
      if (!instr[BIT_UP]) off = -off;
      return off;
   endfunction

   function automatic transfer_type predict_transfer(logic [31:0] instr, logic [31:0] base,
                                                     logic [31:0] rm);
      transfer_type t;
      logic         is_load;
      is_load    = instr[BIT_LOAD];
      t.wb_value = base + transfer_offset(instr, rm);
      t.addr     = instr[BIT_PRE_INDEX] ? t.wb_value : base;
      t.wb_en    = !instr[BIT_PRE_INDEX];
      t.data_reg = instr[15:12];
      t.base_reg = instr[19:16];
      if ({1'b0, t.addr} >= {1'b0, map_cfg.gpio_base} &&
          {1'b0, t.addr} <= {1'b0, map_cfg.gpio_base} + {25'h0, map_cfg.gpio_span})
         t.kind = is_load ? KIND_GPIO_LOAD : KIND_GPIO_STORE;
      else if (t.addr == map_cfg.clear_addr)
         t.kind = KIND_GPIO_CLEAR;
      else if (t.addr == map_cfg.set_addr)
         t.kind = KIND_GPIO_SET;
      else if (t.addr[31] || t.addr > {1'b0, map_cfg.mem_limit})
         t.kind = KIND_OOB;
      else
         t.kind = is_load ? KIND_LOAD : KIND_STORE;
      return t;
   endfunction

   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            pending_transfers.push_back(req_typed ? req_typed_value :
               predict_transfer(req_instr_word, req_base_value, req_offset_reg_value));
         if (rsp_strobe) begin
            if (pending_transfers.size() == 0) begin
               fail_count++;
               $display("%0t: result with no request outstanding, addr 0x%08h",
                        $time, rsp_access_addr);
            end else begin
               oldest = pending_transfers.pop_front();
               kind_seen[rsp_access_kind]++;
               if (rsp_access_addr !== oldest.addr)
                  report_field("access_addr", oldest.addr, rsp_access_addr);
               if (rsp_access_kind !== oldest.kind)
                  report_field("access_kind", 32'(oldest.kind), 32'(rsp_access_kind));
               if (rsp_data_reg !== oldest.data_reg)
                  report_field("data_reg", 32'(oldest.data_reg), 32'(rsp_data_reg));
               if (rsp_base_reg !== oldest.base_reg)
                  report_field("base_reg", 32'(oldest.base_reg), 32'(rsp_base_reg));
               if (rsp_base_write_en !== oldest.wb_en)
                  report_field("base_write_en", 32'(oldest.wb_en), 32'(rsp_base_write_en));
               if (rsp_base_write_value !== oldest.wb_value)
                  report_field("base_write_value", oldest.wb_value, rsp_base_write_value);
            end
         end
      end
   end

   task automatic send_transfer(logic [31:0] instr, logic [31:0] base, logic [31:0] rm,
                                logic typed, transfer_type want);
      start                <= 1'b1;
      req_instr_word       <= instr;
      req_base_value       <= base;
      req_offset_reg_value <= rm;
      req_typed            <= typed;
      req_typed_value      <= want;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   task automatic maybe_pause(int pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_transfers.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_map_reg(reg_index_type idx, logic [31:0] value);
      logic [31:0] stored;
      case (idx)
         REG_GPIO_BASE:  begin map_cfg.gpio_base  = value;        stored = value; end
         REG_GPIO_SPAN:  begin map_cfg.gpio_span  = value[7:0];   stored = {24'h0, value[7:0]}; end
         REG_GPIO_CLEAR: begin map_cfg.clear_addr = value;        stored = value; end
         REG_GPIO_SET:   begin map_cfg.set_addr   = value;        stored = value; end
         default:        begin map_cfg.mem_limit  = value[30:0];  stored = {1'b0, value[30:0]}; end
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== stored) begin
         fail_count++;
         $display("%0t: register %0d read back, expected 0x%08h, got 0x%08h",
                  $time, idx, stored, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_phase(int phase);
      logic [31:0] base;
      case (phase)
         1: begin
            write_map_reg(REG_GPIO_BASE, 32'hFFFF_FF00);
            write_map_reg(REG_GPIO_SPAN, 32'hFFFF_FFFF);
            write_map_reg(REG_GPIO_CLEAR, 32'h0);
            write_map_reg(REG_GPIO_SET, 32'h7FFF_FFFF);
            write_map_reg(REG_MEM_LIMIT, 32'hFFFF_FFFF);
         end
         2: begin
            write_map_reg(REG_GPIO_BASE, 32'h0);
            write_map_reg(REG_GPIO_SPAN, 32'h0);
            write_map_reg(REG_GPIO_CLEAR, 32'h8000_0000);
            write_map_reg(REG_GPIO_SET, 32'h1);
            write_map_reg(REG_MEM_LIMIT, 32'h8000_0000);
         end
         3: begin
            write_map_reg(REG_GPIO_BASE, 32'hFFFF_FFFF);
            write_map_reg(REG_GPIO_SPAN, 32'h0000_00FF);
            write_map_reg(REG_GPIO_CLEAR, 32'hFFFF_FFFF);
            write_map_reg(REG_GPIO_SET, 32'h100);
            write_map_reg(REG_MEM_LIMIT, 32'h100);
         end
         N_PHASES - 1: begin
            write_map_reg(REG_GPIO_BASE, RESET_GPIO_BASE);
            write_map_reg(REG_GPIO_SPAN, {24'h0, RESET_GPIO_SPAN});
            write_map_reg(REG_GPIO_CLEAR, RESET_GPIO_CLEAR);
            write_map_reg(REG_GPIO_SET, RESET_GPIO_SET);
            write_map_reg(REG_MEM_LIMIT, {1'b0, RESET_MEM_LIMIT});
         end
         default: begin
            base = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'hFFFF);
            write_map_reg(REG_GPIO_BASE, base);
            write_map_reg(REG_GPIO_SPAN, $urandom);
            write_map_reg(REG_GPIO_CLEAR, base + $urandom_range(0, 300));
            write_map_reg(REG_GPIO_SET, base + $urandom_range(0, 300));
            write_map_reg(REG_MEM_LIMIT,
                          $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'hF_FFFF));
         end
      endcase
   endtask

   task automatic send_random_transfer();
      logic [31:0] instr;
      logic [31:0] base;
      logic [31:0] rm;
      logic [31:0] target;
      instr = $urandom;
      base  = $urandom;
      rm    = $urandom;
      if ($urandom_range(0, 99) >= 15) begin
         case ($urandom_range(0, 7))
            0: target = map_cfg.gpio_base + $urandom_range(0, map_cfg.gpio_span);
            1: target = map_cfg.gpio_base - 1;
            2: target = map_cfg.gpio_base + map_cfg.gpio_span + 1;
            3: target = map_cfg.clear_addr;
            4: target = map_cfg.set_addr;
            5: target = {1'b0, map_cfg.mem_limit} + $urandom_range(0, 1);
            6: target = $urandom % ({1'b0, map_cfg.mem_limit} + 32'd1);
            default: target = $urandom;
         endcase
         base = instr[BIT_PRE_INDEX] ? target - transfer_offset(instr, rm) : target;
      end
      send_transfer(instr, base, rm, 1'b0, '0);
   endtask

   initial begin
      int idle_pct;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_transfer(DIRECTED_ROWS[i].instr, DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].rm,
                       DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
         maybe_pause(30);
      end
      for (int phase = 0; phase < N_PHASES; phase++) begin
         if (phase > 0) begin
            wait_for_drain();
            program_phase(phase);
         end
         idle_pct = (phase == N_PHASES - 1) ? 0 : $urandom_range(0, 3) * 20;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random_transfer();
            maybe_pause(idle_pct);
         end
      end
      wait_for_drain();
      $display("Sent %0d requests (%0d directed) across %0d address map settings.",
               requests_sent, N_DIRECTED, N_PHASES);
      $display("Kinds seen: load %0d, store %0d, gpio load %0d, gpio store %0d, %s %0d %0d %0d",
               kind_seen[KIND_LOAD], kind_seen[KIND_STORE], kind_seen[KIND_GPIO_LOAD],
               kind_seen[KIND_GPIO_STORE], "clear/set/out of bounds",
               kind_seen[KIND_GPIO_CLEAR], kind_seen[KIND_GPIO_SET], kind_seen[KIND_OOB]);
      if (fail_count == 0)
         $display("[load_store_address_unit_core] OK");
      else
         $display("[load_store_address_unit_core] ERROR");
      $finish;
   end

endmodule
